[rtl/core/gvf_pkg.sv]
// Shared types, constants and codes of the gravity vector fusion block.
package gvf_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W  = 16;
   localparam int CORR_W    = SAMPLE_W + 1;
   localparam int GRAV_W    = 32;
   localparam int GAIN_W    = 32;
   localparam int ACC_W     = GRAV_W + 2;
   localparam int MUL_W     = GAIN_W + 1;
   localparam int PROD_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Accel filter shift and fraction bits of angle deltas and rotation terms
   localparam int FILTER_SHIFT = 8;
   localparam int FRAC_SHIFT   = 16;
   localparam int Q_W          = GRAV_W + 1;

   // Delta saturation limits
   localparam logic [Q_W-1:0]    Q_POS_MAX = Q_W'(33'h0_7FFF_FFFF);
   localparam logic [Q_W-1:0]    Q_NEG_MAX = Q_W'(33'h0_8000_0000);
   localparam logic [GRAV_W-1:0] D_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [GRAV_W-1:0] D_NEG_MAX = 32'h8000_0000;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_ACC_OFF_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACC_OFF_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACC_OFF_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GYR_OFF_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GYR_OFF_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GYR_OFF_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_GAIN = 3'd6;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ACCEL = 2'd1,
      OP_GYRO  = 2'd2
   } opcode_type;

   // Gyro sequence: three gain multiplies, six cross products, one final fold
   typedef enum logic [3:0] {
      STEP_MUL_DX = 4'd0,
      STEP_MUL_DY = 4'd1,
      STEP_MUL_DZ = 4'd2,
      STEP_Z_A    = 4'd3,
      STEP_Z_B    = 4'd4,
      STEP_X_A    = 4'd5,
      STEP_X_B    = 4'd6,
      STEP_Y_A    = 4'd7,
      STEP_Y_B    = 4'd8,
      STEP_FOLD_Y = 4'd9
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIMPLE,
      ST_GYRO,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0][SAMPLE_W-1:0] acc_off;
      logic [2:0][SAMPLE_W-1:0] gyr_off;
      logic [GAIN_W-1:0]        rate_gain;
   } cfg_type;

   typedef struct packed {
      logic     capture;
      logic     simple;
      logic     gyro;
      step_type step;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_gyro;
   } status_type;

endpackage

[rtl/core/gvf_csr.sv]
// Configuration registers: sensor offsets and gyro rate gain.
module gvf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gvf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gvf_pkg::CSR_DAT_W-1:0]  csr_data,
   output gvf_pkg::cfg_type               cfg
);
   import gvf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Always able to take a word
   assign csr_ready = 1'b1;

   // Decode the index; words beyond the register list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ACC_OFF_X: cfg_in.acc_off[0] = csr_data[SAMPLE_W-1:0];
            REG_ACC_OFF_Y: cfg_in.acc_off[1] = csr_data[SAMPLE_W-1:0];
            REG_ACC_OFF_Z: cfg_in.acc_off[2] = csr_data[SAMPLE_W-1:0];
            REG_GYR_OFF_X: cfg_in.gyr_off[0] = csr_data[SAMPLE_W-1:0];
            REG_GYR_OFF_Y: cfg_in.gyr_off[1] = csr_data[SAMPLE_W-1:0];
            REG_GYR_OFF_Z: cfg_in.gyr_off[2] = csr_data[SAMPLE_W-1:0];
            REG_RATE_GAIN: cfg_in.rate_gain  = csr_data[GAIN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/gvf_datapath.sv]
// Datapath: sample correction, accel filter, gain and cross-product multiplier.
module gvf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  gvf_pkg::cmd_type                    cmd,
   output gvf_pkg::status_type                 status,
   input  gvf_pkg::cfg_type                    cfg,
   input  logic [1:0]                          req_opcode,
   input  logic signed [gvf_pkg::SAMPLE_W-1:0] req_sample_x,
   input  logic signed [gvf_pkg::SAMPLE_W-1:0] req_sample_y,
   input  logic signed [gvf_pkg::SAMPLE_W-1:0] req_sample_z,
   output logic signed [gvf_pkg::GRAV_W-1:0]   rsp_grav_x,
   output logic signed [gvf_pkg::GRAV_W-1:0]   rsp_grav_y,
   output logic signed [gvf_pkg::GRAV_W-1:0]   rsp_grav_z
);
   import gvf_pkg::*;

   opcode_type                op_ff, op_in;
   logic signed [CORR_W-1:0]  corr_ff [3];
   logic signed [CORR_W-1:0]  corr_in [3];
   logic signed [GRAV_W-1:0]  grav_ff [3];
   logic signed [GRAV_W-1:0]  grav_in [3];
   logic signed [GRAV_W-1:0]  delta_ff [3];
   logic signed [GRAV_W-1:0]  rsp_ff [3];
   logic signed [SAMPLE_W-1:0] sample [3];

   logic signed [PROD_W-1:0]  prod_ff, pa_ff, prod_in;
   logic signed [GRAV_W-1:0]  tz_ff, tx_ff;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;

   logic                      fold_en;
   logic [1:0]                fold_idx;
   logic [Q_W-1:0]            fold_q;
   logic [GRAV_W-1:0]         fold_d;
   logic [1:0]                mag_idx;
   logic signed [CORR_W-1:0]  mag_src;
   logic [CORR_W-1:0]         mag;
   logic signed [PROD_W-1:0]  cross_diff;
   logic signed [GRAV_W-1:0]  term;

   assign sample[0] = req_sample_x;
   assign sample[1] = req_sample_y;
   assign sample[2] = req_sample_z;

   assign status.req_gyro = (req_opcode == OP_GYRO);

   // Subtract the gyro bias or the accel offset as the word is taken
   always_comb begin
      logic signed [SAMPLE_W-1:0] off;
      off = '0;
      op_in = opcode_type'(req_opcode);
      for (int i = 0; i < 3; i++) begin
         off = (req_opcode == OP_GYRO) ? $signed(cfg.gyr_off[i]) : $signed(cfg.acc_off[i]);
         corr_in[i] = CORR_W'(sample[i]) - CORR_W'(off);
      end
   end

   // Select multiplier operands for the current step
   always_comb begin
      mag_idx = 2'd0;
      case (cmd.step)
         STEP_MUL_DY: mag_idx = 2'd1;
         STEP_MUL_DZ: mag_idx = 2'd2;
         default:     mag_idx = 2'd0;
      endcase
      mag_src = corr_ff[mag_idx];
      mag = mag_src[CORR_W-1] ? CORR_W'(-mag_src) : CORR_W'(mag_src);
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_MUL_DX, STEP_MUL_DY, STEP_MUL_DZ: begin
            mul_a = $signed(MUL_W'(mag));
            mul_b = $signed(MUL_W'(cfg.rate_gain));
         end
         STEP_Z_A: begin
            mul_a = MUL_W'(delta_ff[1]);
            mul_b = MUL_W'(grav_ff[0]);
         end
         STEP_Z_B: begin
            mul_a = MUL_W'(delta_ff[0]);
            mul_b = MUL_W'(grav_ff[1]);
         end
         STEP_X_A: begin
            mul_a = MUL_W'(delta_ff[1]);
            mul_b = MUL_W'(grav_ff[2]);
         end
         STEP_X_B: begin
            mul_a = MUL_W'(delta_ff[2]);
            mul_b = MUL_W'(grav_ff[1]);
         end
         STEP_Y_A: begin
            mul_a = MUL_W'(delta_ff[0]);
            mul_b = MUL_W'(grav_ff[2]);
         end
         STEP_Y_B: begin
            mul_a = MUL_W'(delta_ff[2]);
            mul_b = MUL_W'(grav_ff[0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p   = mul_a * mul_b;
      prod_in = mul_p[PROD_W-1:0];
   end

   // Turn the previous gain product into a saturated Q16.16 angle delta
   always_comb begin
      fold_en  = 1'b0;
      fold_idx = 2'd0;
      case (cmd.step)
         STEP_MUL_DY: begin
            fold_en  = 1'b1;
            fold_idx = 2'd0;
         end
         STEP_MUL_DZ: begin
            fold_en  = 1'b1;
            fold_idx = 2'd1;
         end
         STEP_Z_A: begin
            fold_en  = 1'b1;
            fold_idx = 2'd2;
         end
         default: begin
            fold_en  = 1'b0;
            fold_idx = 2'd0;
         end
      endcase
      fold_q = prod_ff[FRAC_SHIFT+Q_W-1:FRAC_SHIFT];
      if (corr_ff[fold_idx][CORR_W-1]) begin
         fold_d = (fold_q > Q_NEG_MAX) ? D_NEG_MAX : GRAV_W'(Q_W'(0) - fold_q);
      end else begin
         fold_d = (fold_q > Q_POS_MAX) ? D_POS_MAX : fold_q[GRAV_W-1:0];
      end
   end

   // Rotation term: bits 16 to 47 of the difference of a product pair
   assign cross_diff = pa_ff - prod_ff;
   assign term       = cross_diff[FRAC_SHIFT+GRAV_W-1:FRAC_SHIFT];

   // Next estimate
   always_comb begin
      logic signed [ACC_W-1:0] diff;
      diff = '0;
      for (int i = 0; i < 3; i++) begin
         grav_in[i] = grav_ff[i];
      end
      if (cmd.simple) begin
         case (op_ff)
            OP_INIT: begin
               for (int i = 0; i < 3; i++) begin
                  grav_in[i] = GRAV_W'(corr_ff[i]);
               end
            end
            OP_ACCEL: begin
               for (int i = 0; i < 3; i++) begin
                  diff = ACC_W'(corr_ff[i]) - ACC_W'(grav_ff[i]);
                  grav_in[i] = grav_ff[i] + GRAV_W'(diff >>> FILTER_SHIFT);
               end
            end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  grav_in[i] = grav_ff[i];
               end
            end
         endcase
      end
      if (cmd.gyro && cmd.step == STEP_FOLD_Y) begin
         grav_in[0] = grav_ff[0] - tx_ff;
         grav_in[1] = grav_ff[1] + term;
         grav_in[2] = grav_ff[2] + tz_ff;
      end
   end

   // Estimate state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            grav_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            grav_ff[i] <= grav_in[i];
         end
      end
   end

   // Working registers and result word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_in;
         for (int i = 0; i < 3; i++) begin
            corr_ff[i] <= corr_in[i];
         end
      end
      if (cmd.gyro) begin
         prod_ff <= prod_in;
         pa_ff   <= prod_ff;
         if (fold_en) begin
            delta_ff[fold_idx] <= $signed(fold_d);
         end
         if (cmd.step == STEP_X_A) begin
            tz_ff <= term;
         end
         if (cmd.step == STEP_Y_A) begin
            tx_ff <= term;
         end
      end
      if (cmd.load_rsp) begin
         for (int i = 0; i < 3; i++) begin
            rsp_ff[i] <= grav_ff[i];
         end
      end
   end

   assign rsp_grav_x = rsp_ff[0];
   assign rsp_grav_y = rsp_ff[1];
   assign rsp_grav_z = rsp_ff[2];

endmodule

[rtl/core/gvf_ctrl.sv]
// Controller: item sequencing, gyro step counter and result handshake.
module gvf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gvf_pkg::cmd_type    cmd,
   input  gvf_pkg::status_type status
);
   import gvf_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.step     = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_gyro ? ST_GYRO : ST_SIMPLE;
            end
         end
         ST_SIMPLE: begin
            cmd.simple = 1'b1;
            state_in   = ST_DONE;
         end
         ST_GYRO: begin
            cmd.gyro = 1'b1;
            if (step_ff == STEP_FOLD_Y) begin
               step_in  = STEP_MUL_DX;
               state_in = ST_DONE;
            end else begin
               step_in = step_type'(step_ff + 4'd1);
            end
         end
         ST_DONE: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MUL_DX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a word not yet taken");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("result loaded but not shown as valid");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_GYRO) |-> (step_ff == STEP_MUL_DX))
      else $error("gyro step counter not parked outside the gyro sequence");

   a_gyro_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GYRO && step_ff == STEP_FOLD_Y) |=> (state_ff == ST_DONE))
      else $error("gyro sequence did not finish after its last step");
`endif

endmodule

[rtl/core/gravity_vector_gyro_acc_fusion.sv]
// Top level of the gravity vector estimator fusing accelerometer and gyro words.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_opcode, req_sample_x/y/z
//   rsp      out        rsp_valid/rsp_ready    rsp_grav_x/y/z
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A word is taken only in idle. Init, accel or unused-opcode word: a simple update state,
// then the done state loads the result. Gyro word: the gyro steps run first, as the one
// shared 33x33 multiplier does three gain products and six cross products, then a fold.
// The next word is taken while the previous result still waits in the output register.
// Synchronous reset clears the estimate, the offsets and the gain to zero.
// A stalled rsp side parks the controller until the output register frees; csr_ready is 1.
module gravity_vector_gyro_acc_fusion (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic signed [gvf_pkg::SAMPLE_W-1:0] req_sample_x,
   input  logic signed [gvf_pkg::SAMPLE_W-1:0] req_sample_y,
   input  logic signed [gvf_pkg::SAMPLE_W-1:0] req_sample_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gvf_pkg::GRAV_W-1:0]   rsp_grav_x,
   output logic signed [gvf_pkg::GRAV_W-1:0]   rsp_grav_y,
   output logic signed [gvf_pkg::GRAV_W-1:0]   rsp_grav_z,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gvf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gvf_pkg::CSR_DAT_W-1:0]       csr_data
);
   import gvf_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   gvf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   gvf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .req_opcode   (req_opcode),
      .req_sample_x (req_sample_x),
      .req_sample_y (req_sample_y),
      .req_sample_z (req_sample_z),
      .rsp_grav_x   (rsp_grav_x),
      .rsp_grav_y   (rsp_grav_y),
      .rsp_grav_z   (rsp_grav_z)
   );

endmodule
